// ----- rtl/rhpm_pkg.sv -----
// Shared types and constants for the RGB to HSL palette matcher.
package rhpm_pkg;

	localparam int IDX_W   = 8;
	localparam int HUE_W   = 9;
	localparam int PCT_W   = 7;
	localparam int CH_W    = 8;
	localparam int NUM_W   = 17;
	localparam int DEN_W   = 9;
	localparam int QUO_W   = 9;
	localparam int DIST_W  = 19;
	localparam int LANES   = 2;
	localparam int LANE_H  = 0;
	localparam int LANE_S  = 1;
	localparam logic [DEN_W-1:0] LIGHT_DEN = 9'd510;
	localparam logic [HUE_W-1:0] FULL_TURN = 9'd360;
	localparam logic [DIST_W-1:0] DIST_MAX = '1;
	// lightness = floor(sum * 10 / 51) = (sum * 6426) >> 15 for sum up to 510
	localparam int LMUL_W      = 22;
	localparam logic [12:0] LIGHT_MUL = 13'd6426;
	localparam int LIGHT_SHIFT = 15;

	// palette entry / pixel HSL triple
	typedef struct packed {
		logic [HUE_W-1:0] hue;
		logic [PCT_W-1:0] sat;
		logic [PCT_W-1:0] light;
	} hsl_t;

	// item moving through the divider stages
	typedef struct packed {
		logic                               vld;
		logic                               pix;
		logic [IDX_W-1:0]                   idx;
		hsl_t                               ent;
		logic                               zero;
		logic                               neg;
		logic [PCT_W-1:0]                   light;
		logic [LANES-1:0][NUM_W-1:0]        num;
		logic [LANES-1:0][DEN_W-1:0]        den;
		logic [LANES-1:0][QUO_W-1:0]        quo;
	} conv_t;

	// item moving along the palette cells
	typedef struct packed {
		logic              vld;
		logic              pix;
		logic [IDX_W-1:0]  idx;
		hsl_t              hsl;
		logic [IDX_W-1:0]  best_idx;
		logic [DIST_W-1:0] best_dist;
		logic [DIST_W-1:0] cand_dist;
	} tok_t;

endpackage

// ----- rtl/rhpm_div_stage.sv -----
// One restoring-division step for the hue and saturation lanes.
module rhpm_div_stage import rhpm_pkg::*; #(
	parameter int BIT = 0
) (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  en,
	input  conv_t d,
	output conv_t q
);

	conv_t nxt;
	logic [NUM_W:0] sh;

	always_comb begin
		nxt = d;
		sh  = '0;
		for (int i = 0; i < LANES; i++) begin
			sh = (NUM_W+1)'(d.den[i]) << BIT;
			if ((NUM_W+1)'(d.num[i]) >= sh) begin
				nxt.num[i]      = NUM_W'((NUM_W+1)'(d.num[i]) - sh);
				nxt.quo[i][BIT] = 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			q <= '0;
		end else if (en) begin
			q <= nxt;
		end
	end

endmodule

// ----- rtl/rhpm_cell.sv -----
// One palette cell: holds an entry, scores the passing pixel, keeps the running best.
module rhpm_cell import rhpm_pkg::*; #(
	parameter int IDX = 0
) (
	input  logic clk,
	input  logic arst_n,
	input  logic en,
	input  tok_t tin,
	output tok_t tout
);

	hsl_t              ent_q;
	logic [HUE_W-1:0]  dh;
	logic [PCT_W-1:0]  ds, dl;
	logic [DIST_W-1:0] score;
	logic              upd;

	always_comb begin
		dh   = (tin.hsl.hue >= ent_q.hue) ? tin.hsl.hue - ent_q.hue : ent_q.hue - tin.hsl.hue;
		ds   = (tin.hsl.sat >= ent_q.sat) ? tin.hsl.sat - ent_q.sat : ent_q.sat - tin.hsl.sat;
		dl   = (tin.hsl.light >= ent_q.light) ? tin.hsl.light - ent_q.light
			: ent_q.light - tin.hsl.light;
		score = DIST_W'(dh) * DIST_W'(dh) + DIST_W'(ds) * DIST_W'(ds)
			+ DIST_W'(dl) * DIST_W'(dl);
		// candidate belongs to the previous cell's entry
		upd  = tin.cand_dist < tin.best_dist;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ent_q <= '0;
			tout  <= '0;
		end else if (en) begin
			if (tin.vld && !tin.pix && tin.idx == IDX_W'(IDX)) begin
				ent_q <= tin.hsl;
			end
			tout           <= tin;
			tout.best_idx  <= upd ? IDX_W'(IDX - 1) : tin.best_idx;
			tout.best_dist <= upd ? tin.cand_dist : tin.best_dist;
			tout.cand_dist <= score;
		end
	end

endmodule

// ----- rtl/rgb_to_hsl_palette_match_top.sv -----
// Top level of the RGB to HSL nearest-palette matcher.
// Each item is either a palette write (tuser = 0) or a pixel (tuser = 1). A pixel is
// converted to HSL (hue in whole degrees, saturation and lightness in whole percent, all
// truncated) by a nine-step pipelined divider, then walks a row of PALETTE_SIZE cells, one
// cell per cycle; each cell holds one palette entry, scores the pixel by squared HSL
// distance and hands the running best on to its neighbor, lowest index winning ties.
// Palette writes ride the same row and land in their cell on the way, so every pixel
// sees exactly the writes that were accepted before it. One item is accepted per clock
// while the output is not stalled; a pixel passes stages 1 to 3, the divider, stage 4,
// the cell row and the output register. Writes produce no result. The palette is all
// zero after reset with no clearing time. A stalled output holds the whole pipeline.
module rgb_to_hsl_palette_match_top import rhpm_pkg::*; #(
	parameter int PALETTE_SIZE = 256
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	// entry_index[7:0], entry_hue[16:8], entry_sat[23:17], entry_light[30:24],
	// red[38:31], green[46:39], blue[54:47], zero fill [55]
	input  logic [55:0] s_tdata,
	// req_type[0]
	input  logic [0:0]  s_tuser,
	output logic        m_tvalid,
	input  logic        m_tready,
	// palette_index[7:0], hue[16:8], saturation[23:17], lightness[30:24], zero fill [31]
	output logic [31:0] m_tdata
);

	typedef struct packed {
		logic             vld;
		logic             pix;
		logic [IDX_W-1:0] idx;
		hsl_t             ent;
		logic [CH_W-1:0]  r, g, b;
	} raw_t;

	typedef struct packed {
		logic             vld;
		logic             pix;
		logic [IDX_W-1:0] idx;
		hsl_t             ent;
		logic [CH_W-1:0]  r, g, b;
		logic [CH_W-1:0]  d;
		logic [DEN_W-1:0] sum;
		logic             selr, selg;
	} mid_t;

	logic en;
	raw_t raw_s1;
	mid_t mid_s2, mid_d;
	conv_t conv_s3, conv_d;
	conv_t dv [QUO_W+1];
	tok_t  tok_s4, tok_d;
	tok_t  chain [PALETTE_SIZE+1];
	logic [CH_W-1:0] mx, mn;
	logic [HUE_W-1:0] hue_f;
	logic last_upd;
	logic [IDX_W-1:0] out_idx;

	// whole pipeline moves unless a result is waiting
	assign en       = !m_tvalid || m_tready;
	assign s_tready = en;

	// stage 1: capture item
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			raw_s1 <= '0;
		end else if (en) begin
			raw_s1.vld       <= s_tvalid;
			raw_s1.pix       <= s_tuser[0];
			raw_s1.idx       <= s_tdata[7:0];
			raw_s1.ent.hue   <= s_tdata[16:8];
			raw_s1.ent.sat   <= s_tdata[23:17];
			raw_s1.ent.light <= s_tdata[30:24];
			raw_s1.r         <= s_tdata[38:31];
			raw_s1.g         <= s_tdata[46:39];
			raw_s1.b         <= s_tdata[54:47];
		end
	end

	// stage 2: max, min, chroma, sum
	always_comb begin
		mx = raw_s1.r;
		mn = raw_s1.r;
		if (raw_s1.g > mx) mx = raw_s1.g;
		if (raw_s1.b > mx) mx = raw_s1.b;
		if (raw_s1.g < mn) mn = raw_s1.g;
		if (raw_s1.b < mn) mn = raw_s1.b;
		mid_d.vld  = raw_s1.vld;
		mid_d.pix  = raw_s1.pix;
		mid_d.idx  = raw_s1.idx;
		mid_d.ent  = raw_s1.ent;
		mid_d.r    = raw_s1.r;
		mid_d.g    = raw_s1.g;
		mid_d.b    = raw_s1.b;
		mid_d.d    = mx - mn;
		mid_d.sum  = DEN_W'(mx) + DEN_W'(mn);
		mid_d.selr = (mx == raw_s1.r);
		mid_d.selg = (mx == raw_s1.g);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mid_s2 <= '0;
		end else if (en) begin
			mid_s2 <= mid_d;
		end
	end

	// stage 3: numerators and denominators for hue and saturation, lightness by reciprocal
	always_comb begin
		conv_d      = '0;
		conv_d.vld  = mid_s2.vld;
		conv_d.pix  = mid_s2.pix;
		conv_d.idx  = mid_s2.idx;
		conv_d.ent  = mid_s2.ent;
		conv_d.zero = (mid_s2.d == '0);
		conv_d.neg  = mid_s2.selr && (mid_s2.g < mid_s2.b);
		if (mid_s2.selr) begin
			if (mid_s2.g >= mid_s2.b) begin
				conv_d.num[LANE_H] = NUM_W'(60) * NUM_W'(mid_s2.g - mid_s2.b);
			end else begin
				// ceiling of the hue step, subtracted from a full turn later
				conv_d.num[LANE_H] = NUM_W'(60) * NUM_W'(mid_s2.b - mid_s2.g)
					+ NUM_W'(mid_s2.d) - NUM_W'(1);
			end
		end else if (mid_s2.selg) begin
			conv_d.num[LANE_H] = NUM_W'(120) * NUM_W'(mid_s2.d)
				+ NUM_W'(60) * NUM_W'(mid_s2.b) - NUM_W'(60) * NUM_W'(mid_s2.r);
		end else begin
			conv_d.num[LANE_H] = NUM_W'(240) * NUM_W'(mid_s2.d)
				+ NUM_W'(60) * NUM_W'(mid_s2.r) - NUM_W'(60) * NUM_W'(mid_s2.g);
		end
		conv_d.den[LANE_H] = DEN_W'(mid_s2.d);
		conv_d.num[LANE_S] = NUM_W'(100) * NUM_W'(mid_s2.d);
		conv_d.den[LANE_S] = (mid_s2.sum <= DEN_W'(255)) ? mid_s2.sum : LIGHT_DEN - mid_s2.sum;
		conv_d.light = PCT_W'((LMUL_W'(mid_s2.sum) * LMUL_W'(LIGHT_MUL)) >> LIGHT_SHIFT);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			conv_s3 <= '0;
		end else if (en) begin
			conv_s3 <= conv_d;
		end
	end

	// divider: one quotient bit per stage, most significant first
	assign dv[0] = conv_s3;
	for (genvar k = 0; k < QUO_W; k++) begin : g_div
		rhpm_div_stage #(.BIT(QUO_W - 1 - k)) u_stage (
			.clk    (clk),
			.arst_n (arst_n),
			.en     (en),
			.d      (dv[k]),
			.q      (dv[k+1])
		);
	end

	// stage 4: finish HSL and seed the cell row
	always_comb begin
		hue_f = dv[QUO_W].neg ? FULL_TURN - dv[QUO_W].quo[LANE_H] : dv[QUO_W].quo[LANE_H];
		tok_d           = '0;
		tok_d.vld       = dv[QUO_W].vld;
		tok_d.pix       = dv[QUO_W].pix;
		tok_d.idx       = dv[QUO_W].idx;
		tok_d.best_dist = DIST_MAX;
		tok_d.cand_dist = DIST_MAX;
		if (dv[QUO_W].pix) begin
			tok_d.hsl.hue   = dv[QUO_W].zero ? '0 : hue_f;
			tok_d.hsl.sat   = dv[QUO_W].zero ? '0 : PCT_W'(dv[QUO_W].quo[LANE_S]);
			tok_d.hsl.light = dv[QUO_W].light;
		end else begin
			tok_d.hsl = dv[QUO_W].ent;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tok_s4 <= '0;
		end else if (en) begin
			tok_s4 <= tok_d;
		end
	end

	// palette cell row
	assign chain[0] = tok_s4;
	for (genvar c = 0; c < PALETTE_SIZE; c++) begin : g_cell
		rhpm_cell #(.IDX(c)) u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.en     (en),
			.tin    (chain[c]),
			.tout   (chain[c+1])
		);
	end

	// last candidate is the highest entry
	assign last_upd = chain[PALETTE_SIZE].cand_dist < chain[PALETTE_SIZE].best_dist;
	assign out_idx  = last_upd ? IDX_W'(PALETTE_SIZE - 1) : chain[PALETTE_SIZE].best_idx;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid <= 1'b0;
			m_tdata  <= '0;
		end else if (en) begin
			m_tvalid <= chain[PALETTE_SIZE].vld && chain[PALETTE_SIZE].pix;
			m_tdata  <= {1'b0, chain[PALETTE_SIZE].hsl.light, chain[PALETTE_SIZE].hsl.sat,
				chain[PALETTE_SIZE].hsl.hue, out_idx};
		end
	end

`ifndef SYNTHESIS
	a_hue_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[16:8] < 9'd360)
		else $error("hue out of range");
	a_pct_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tdata[23:17] <= 7'd100 && m_tdata[30:24] <= 7'd100))
		else $error("percent out of range");
	a_idx_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> 32'(m_tdata[7:0]) < 32'(PALETTE_SIZE))
		else $error("palette index out of range");
`endif

endmodule
